// ===== rtl/core/sss_pkg.sv =====
`default_nettype none

package sss_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TALL_OBJECTS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SORT_BY_X    = 1'b1;

   // Object geometry: stored Y carries a bias of 16 lines
   localparam logic [8:0] OBJ_Y_BIAS      = 9'd16;
   localparam logic [8:0] OBJ_HEIGHT_TALL = 9'd16;
   localparam logic [8:0] OBJ_HEIGHT_STD  = 9'd8;

   // Queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One stored object
   typedef struct packed {
      logic [7:0] y;
      logic [7:0] x;
      logic [7:0] tile;
      logic [7:0] flags;
   } slot_type;

   // One classified table entry in flight to the back
   typedef struct packed {
      slot_type obj;
      logic     keep;
      logic     last;
   } queue_entry_type;

   // Queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back-end sequencer states
   typedef enum logic {
      BACK_SCAN,
      BACK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/sss_front.sv =====
`default_nettype none

module sss_front
   import sss_pkg::*;
#(
   parameter int TABLE_ENTRIES = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire queue_status_type q_status,
   input  wire logic             tall_objects,
   input  wire logic [7:0]       scan_line,
   input  wire logic [7:0]       entry_y,
   input  wire logic [7:0]       entry_x,
   input  wire logic [7:0]       entry_tile,
   input  wire logic [7:0]       entry_flags,
   input  wire logic             last_entry,
   output logic                  push,
   output queue_entry_type       push_entry
);

   localparam int ENT_W = $clog2(TABLE_ENTRIES + 1);

   logic [ENT_W-1:0] entries_ff;
   logic [ENT_W-1:0] entries_in;
   logic             in_table;
   logic [8:0]       bottom;
   logic [8:0]       y_end;
   logic             in_window;

   // Transfer takes place when start is high and the queue has room
   assign push     = start && !q_status.full;
   assign in_table = entries_ff < ENT_W'(TABLE_ENTRIES);

   // Line window test in 9 bits so nothing wraps
   assign bottom    = {1'b0, scan_line} + OBJ_Y_BIAS;
   assign y_end     = {1'b0, entry_y} + (tall_objects ? OBJ_HEIGHT_TALL : OBJ_HEIGHT_STD);
   assign in_window = ({1'b0, entry_y} <= bottom) && (y_end > bottom);

   always_comb begin
      push_entry.obj.y     = entry_y;
      push_entry.obj.x     = entry_x;
      push_entry.obj.tile  = entry_tile;
      push_entry.obj.flags = entry_flags;
      push_entry.keep      = in_table && in_window;
      push_entry.last      = last_entry;
   end

   // Entry counter, restarts at the closing entry
   always_comb begin
      entries_in = entries_ff;
      if (push) begin
         if (last_entry) begin
            entries_in = '0;
         end else if (in_table) begin
            entries_in = entries_ff + ENT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sss_queue.sv =====
`default_nettype none

module sss_queue
   import sss_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire queue_entry_type push_entry,
   input  wire logic            pop,
   output queue_entry_type      head,
   output queue_status_type     status
);

   queue_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff;
   logic [QUEUE_CNT_W-1:0] fill_in;

   assign status.full  = fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = fill_ff == '0;
   assign head         = mem_ff[rd_ptr_ff];

   // Pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sss_back.sv =====
`default_nettype none

module sss_back
   import sss_pkg::*;
#(
   parameter int MAX_PER_LINE = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_entry_type  head,
   input  wire queue_status_type q_status,
   input  wire logic             sort_by_x,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_sprite_y,
   output logic [7:0]            rsp_sprite_x,
   output logic [7:0]            rsp_sprite_tile,
   output logic [7:0]            rsp_sprite_flags,
   output logic                  rsp_sprite_valid,
   output logic [3:0]            rsp_selected_count,
   output logic                  rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_PER_LINE + 1);
   localparam int IDX_W = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  emit_idx_ff;
   logic [IDX_W-1:0]  emit_idx_in;
   slot_type          table_ff  [MAX_PER_LINE];
   slot_type          sorted_ff [MAX_PER_LINE];
   logic [MAX_PER_LINE-1:0] gt;
   logic              insert;
   logic              emit_last;
   slot_type          sel;

   assign pop       = (state_ff == BACK_SCAN) && !q_status.empty;
   assign insert    = pop && head.keep && (count_ff < CNT_W'(MAX_PER_LINE));
   assign emit_last = (count_ff == '0)
                      || ((CNT_W'(emit_idx_ff) + CNT_W'(1)) == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_SCAN: begin
            if (pop && head.last) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (emit_last) begin
               state_in = BACK_SCAN;
            end
         end
      endcase
   end

   // Slot count and readout index
   always_comb begin
      count_in    = count_ff;
      emit_idx_in = emit_idx_ff;
      unique case (state_ff)
         BACK_SCAN: begin
            if (insert) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         BACK_EMIT: begin
            if (emit_last) begin
               count_in    = '0;
               emit_idx_in = '0;
            end else begin
               emit_idx_in = emit_idx_ff + IDX_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_SCAN;
         count_ff    <= '0;
         emit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

   // Table-order slots: append at the fill point
   always_ff @(posedge clock) begin
      if (insert) begin
         table_ff[count_ff[IDX_W-1:0]] <= head.obj;
      end
   end

   // X-ordered slots: each lane compares and shifts up on its own
   genvar i;
   generate
      for (i = 0; i < MAX_PER_LINE; i++) begin : g_lane
         assign gt[i] = (CNT_W'(i) < count_ff) && (sorted_ff[i].x > head.obj.x);
         if (i == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (insert && (gt[i] || (count_ff == CNT_W'(i)))) begin
                  sorted_ff[i] <= head.obj;
               end
            end
         end else begin : g_rest
            always_ff @(posedge clock) begin
               if (insert) begin
                  if (gt[i-1]) begin
                     sorted_ff[i] <= sorted_ff[i-1];
                  end else if (gt[i] || (count_ff == CNT_W'(i))) begin
                     sorted_ff[i] <= head.obj;
                  end
               end
            end
         end
      end
   endgenerate

   // Result outputs
   assign sel = sort_by_x ? sorted_ff[emit_idx_ff] : table_ff[emit_idx_ff];

   always_comb begin
      rsp_strobe         = 1'b0;
      rsp_sprite_y       = '0;
      rsp_sprite_x       = '0;
      rsp_sprite_tile    = '0;
      rsp_sprite_flags   = '0;
      rsp_sprite_valid   = 1'b0;
      rsp_selected_count = '0;
      rsp_last_result    = 1'b0;
      unique case (state_ff)
         BACK_SCAN: begin
         end
         BACK_EMIT: begin
            rsp_strobe      = 1'b1;
            rsp_last_result = emit_last;
            if (count_ff != '0) begin
               rsp_sprite_y       = sel.y;
               rsp_sprite_x       = sel.x;
               rsp_sprite_tile    = sel.tile;
               rsp_sprite_flags   = sel.flags;
               rsp_sprite_valid   = 1'b1;
               rsp_selected_count = 4'(count_ff);
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/scanline_sprite_selector_unit.sv =====
// The closing entry is queued and popped; the back end then enters its emit state for its results.
// Throughput: one table entry per cycle while the back end scans and the queue has room; the closing
// entry yields one result per kept object, or one invalid marker, from the single slot readout port.
// busy rises only when the two-entry queue is full; results cannot be stalled.
// Synchronous active-high reset clears all control state and sets tall_objects to 0, sort_by_x to 1.
`default_nettype none

module scanline_sprite_selector_unit
   import sss_pkg::*;
#(
   parameter int MAX_PER_LINE  = 10,
   parameter int TABLE_ENTRIES = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [7:0]                 req_scan_line,
   input  wire logic [7:0]                 req_entry_y,
   input  wire logic [7:0]                 req_entry_x,
   input  wire logic [7:0]                 req_entry_tile,
   input  wire logic [7:0]                 req_entry_flags,
   input  wire logic                       req_last_entry,
   output logic                            rsp_strobe,
   output logic [7:0]                      rsp_sprite_y,
   output logic [7:0]                      rsp_sprite_x,
   output logic [7:0]                      rsp_sprite_tile,
   output logic [7:0]                      rsp_sprite_flags,
   output logic                            rsp_sprite_valid,
   output logic [3:0]                      rsp_selected_count,
   output logic                            rsp_last_result,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic             tall_ff;
   logic             sort_ff;
   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   logic             push;
   logic             pop;

   assign busy = q_status.full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tall_ff <= 1'b0;
         sort_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TALL_OBJECTS: tall_ff <= csr_wdata[0];
            CSR_SORT_BY_X:    sort_ff <= csr_wdata[0];
         endcase
      end
   end

   // Front: transfer and window test
   sss_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .q_status    (q_status),
      .tall_objects(tall_ff),
      .scan_line   (req_scan_line),
      .entry_y     (req_entry_y),
      .entry_x     (req_entry_x),
      .entry_tile  (req_entry_tile),
      .entry_flags (req_entry_flags),
      .last_entry  (req_last_entry),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decoupling queue
   sss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Back: slot storage, ordering and readout
   sss_back #(
      .MAX_PER_LINE(MAX_PER_LINE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .sort_by_x         (sort_ff),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_sprite_y      (rsp_sprite_y),
      .rsp_sprite_x      (rsp_sprite_x),
      .rsp_sprite_tile   (rsp_sprite_tile),
      .rsp_sprite_flags  (rsp_sprite_flags),
      .rsp_sprite_valid  (rsp_sprite_valid),
      .rsp_selected_count(rsp_selected_count),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

`default_nettype wire

// ===== bench/scanline_sprite_selector_checker.sv =====
`timescale 1ns / 1ps

module scanline_sprite_selector_checker
   import sss_pkg::*;
#(
   parameter int MAX_PER_LINE  = 10,
   parameter int TABLE_ENTRIES = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [7:0]                 req_scan_line,
   input  wire logic [7:0]                 req_entry_y,
   input  wire logic [7:0]                 req_entry_x,
   input  wire logic [7:0]                 req_entry_tile,
   input  wire logic [7:0]                 req_entry_flags,
   input  wire logic                       req_last_entry,
   input  wire logic                       rsp_strobe,
   input  wire logic [7:0]                 rsp_sprite_y,
   input  wire logic [7:0]                 rsp_sprite_x,
   input  wire logic [7:0]                 rsp_sprite_tile,
   input  wire logic [7:0]                 rsp_sprite_flags,
   input  wire logic                       rsp_sprite_valid,
   input  wire logic [3:0]                 rsp_selected_count,
   input  wire logic                       rsp_last_result,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   // One emitted sprite as the line buffer should present it
   typedef struct packed {
      logic [7:0] y;
      logic [7:0] x;
      logic [7:0] tile;
      logic [7:0] flags;
      logic       valid;
      logic [3:0] count;
      logic       last;
   } sprite_result_type;

   // Mirror of the selector state and its registers
   slot_type          kept_slots [MAX_PER_LINE];
   int unsigned       kept_count;
   int unsigned       entries_in_scan;
   logic              tall_mode;
   logic              sort_mode;
   sprite_result_type expected_sprites [$];
   sprite_result_type oldest;
   int                errors = 0;

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // Window test and slot fill for one entry; the closing entry emits the line's sprites
   task automatic select_entry(input logic [7:0] line, input logic [7:0] y,
                               input logic [7:0] x, input logic [7:0] tile,
                               input logic [7:0] flags, input logic last);
      logic [9:0]        bottom;
      logic [9:0]        height;
      slot_type          order [MAX_PER_LINE];
      slot_type          moving;
      sprite_result_type res;
      int                i;
      int                j;
      if (entries_in_scan < TABLE_ENTRIES) begin
         entries_in_scan++;
         bottom = {2'b00, line} + {1'b0, OBJ_Y_BIAS};
         height = tall_mode ? {1'b0, OBJ_HEIGHT_TALL} : {1'b0, OBJ_HEIGHT_STD};
         if (kept_count < MAX_PER_LINE && {2'b00, y} <= bottom
             && {2'b00, y} + height > bottom) begin
            kept_slots[kept_count] = {y, x, tile, flags};
            kept_count++;
         end
      end
      if (last) begin
         if (kept_count == 0) begin
            // nothing on this line: a single invalid marker
            res = '0;
            res.last = 1'b1;
            expected_sprites.push_back(res);
         end else begin
            for (i = 0; i < kept_count; i++)
               order[i] = kept_slots[i];
            // stable insertion sort on X; equal X keeps table order
            if (sort_mode) begin
               for (i = 1; i < kept_count; i++) begin
                  moving = order[i];
                  j = i;
                  while (j > 0 && order[j-1].x > moving.x) begin
                     order[j] = order[j-1];
                     j--;
                  end
                  order[j] = moving;
               end
            end
            for (i = 0; i < kept_count; i++) begin
               res.y     = order[i].y;
               res.x     = order[i].x;
               res.tile  = order[i].tile;
               res.flags = order[i].flags;
               res.valid = 1'b1;
               res.count = kept_count[3:0];
               res.last  = (i + 1 == kept_count);
               expected_sprites.push_back(res);
            end
         end
         kept_count      = 0;
         entries_in_scan = 0;
      end
   endtask

   // Monitor: compare results, track register writes, predict each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         expected_sprites.delete();
         kept_count      = 0;
         entries_in_scan = 0;
         tall_mode       = 1'b0;
         sort_mode       = 1'b1;
      end else begin
         if (rsp_strobe) begin
            if (expected_sprites.size() == 0) begin
               $error("sprite result with nothing expected");
               errors++;
            end else begin
               oldest = expected_sprites.pop_front();
               check_field("sprite_y", oldest.y, rsp_sprite_y);
               check_field("sprite_x", oldest.x, rsp_sprite_x);
               check_field("sprite_tile", oldest.tile, rsp_sprite_tile);
               check_field("sprite_flags", oldest.flags, rsp_sprite_flags);
               check_field("sprite_valid", oldest.valid, rsp_sprite_valid);
               check_field("selected_count", oldest.count, rsp_selected_count);
               check_field("last_result", oldest.last, rsp_last_result);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TALL_OBJECTS: tall_mode = csr_wdata[0];
               CSR_SORT_BY_X:    sort_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy)
            select_entry(req_scan_line, req_entry_y, req_entry_x, req_entry_tile,
                         req_entry_flags, req_last_entry);
      end
      pending    <= expected_sprites.size();
      fail_count <= errors;
   end

endmodule

// ===== bench/tb_scanline_sprite_selector_unit.sv =====
`timescale 1ns / 1ps

module tb_scanline_sprite_selector_unit;
   import sss_pkg::*;

   localparam int MAX_PER_LINE  = 10;
   localparam int TABLE_ENTRIES = 40;
   localparam int TOTAL_ITEMS   = 210;
   localparam int CYCLE_LIMIT   = 100000;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [7:0]                 req_scan_line = '0;
   logic [7:0]                 req_entry_y = '0;
   logic [7:0]                 req_entry_x = '0;
   logic [7:0]                 req_entry_tile = '0;
   logic [7:0]                 req_entry_flags = '0;
   logic                       req_last_entry = 1'b0;
   logic                       rsp_strobe;
   logic [7:0]                 rsp_sprite_y;
   logic [7:0]                 rsp_sprite_x;
   logic [7:0]                 rsp_sprite_tile;
   logic [7:0]                 rsp_sprite_flags;
   logic                       rsp_sprite_valid;
   logic [3:0]                 rsp_selected_count;
   logic                       rsp_last_result;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   int                         fail_count;
   int                         pending;

   // Stimulus bookkeeping
   int   items_sent = 0;
   int   burst_left = 0;
   logic tall_setting = 1'b0;
   int   cycles = 0;

   scanline_sprite_selector_unit #(
      .MAX_PER_LINE (MAX_PER_LINE),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_scan_line     (req_scan_line),
      .req_entry_y       (req_entry_y),
      .req_entry_x       (req_entry_x),
      .req_entry_tile    (req_entry_tile),
      .req_entry_flags   (req_entry_flags),
      .req_last_entry    (req_last_entry),
      .rsp_strobe        (rsp_strobe),
      .rsp_sprite_y      (rsp_sprite_y),
      .rsp_sprite_x      (rsp_sprite_x),
      .rsp_sprite_tile   (rsp_sprite_tile),
      .rsp_sprite_flags  (rsp_sprite_flags),
      .rsp_sprite_valid  (rsp_sprite_valid),
      .rsp_selected_count(rsp_selected_count),
      .rsp_last_result   (rsp_last_result),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   scanline_sprite_selector_checker #(
      .MAX_PER_LINE (MAX_PER_LINE),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_scan_line     (req_scan_line),
      .req_entry_y       (req_entry_y),
      .req_entry_x       (req_entry_x),
      .req_entry_tile    (req_entry_tile),
      .req_entry_flags   (req_entry_flags),
      .req_last_entry    (req_last_entry),
      .rsp_strobe        (rsp_strobe),
      .rsp_sprite_y      (rsp_sprite_y),
      .rsp_sprite_x      (rsp_sprite_x),
      .rsp_sprite_tile   (rsp_sprite_tile),
      .rsp_sprite_flags  (rsp_sprite_flags),
      .rsp_sprite_valid  (rsp_sprite_valid),
      .rsp_selected_count(rsp_selected_count),
      .rsp_last_result   (rsp_last_result),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // One table entry transfer; returns at the edge that accepted it
   task automatic send_entry(input logic [7:0] line, input logic [7:0] y,
                             input logic [7:0] x, input logic [7:0] tile,
                             input logic [7:0] flags, input logic last);
      start           <= 1'b1;
      req_scan_line   <= line;
      req_entry_y     <= y;
      req_entry_x     <= x;
      req_entry_tile  <= tile;
      req_entry_flags <= flags;
      req_last_entry  <= last;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Burst/gap pacing of the sender
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Hold off until every sprite is out, then let the pipeline drain
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_TALL_OBJECTS)
         tall_setting = val[0];
   endtask

   // Y byte that lands inside the line's window when asked to and such a Y fits in a byte
   function automatic logic [7:0] pick_y(input logic [7:0] line, input bit hit);
      int h;
      int v;
      h = tall_setting ? int'(OBJ_HEIGHT_TALL) : int'(OBJ_HEIGHT_STD);
      v = int'(line) + int'(OBJ_Y_BIAS) - int'($urandom_range(0, h - 1));
      if (!hit || v > 255)
         return 8'($urandom_range(0, 255));
      return v[7:0];
   endfunction

   // One random scan; overrun scans put most of their matches past the table end
   task automatic run_scan(input int length, input bit overrun);
      logic [7:0] line;
      logic [7:0] line_now;
      bit         narrow_x;
      bit         hit;
      int         n;
      line     = 8'($urandom_range(0, 255));
      narrow_x = ($urandom_range(0, 2) == 0);
      for (n = 0; n < length; n++) begin
         if (overrun)
            hit = (n >= TABLE_ENTRIES) || ($urandom_range(0, 19) == 0);
         else
            hit = ($urandom_range(0, 9) < 6);
         // occasional stray line number as noise
         line_now = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : line;
         send_entry(line_now, pick_y(line_now, hit),
                    narrow_x ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    n == length - 1);
         pace();
      end
   endtask

   // Stimulus
   initial begin
      int  scan_no;
      int  i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset config: empty line gives the invalid marker
      send_entry(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      pace();

      // Window edges at 8 lines, equal X, X extremes, sorted
      send_entry(8'd100, 8'd116, 8'd50, 8'h01, 8'h00, 1'b0);
      pace();
      send_entry(8'd100, 8'd109, 8'd20, 8'h02, 8'hFF, 1'b0);
      pace();
      send_entry(8'd100, 8'd108, 8'd30, 8'h03, 8'h80, 1'b0);
      pace();
      send_entry(8'd100, 8'd117, 8'd40, 8'h04, 8'h7F, 1'b0);
      pace();
      send_entry(8'd100, 8'd116, 8'd50, 8'h05, 8'h10, 1'b0);
      pace();
      send_entry(8'd100, 8'd112, 8'd0, 8'h06, 8'h01, 1'b0);
      pace();
      send_entry(8'd100, 8'd110, 8'd255, 8'hFF, 8'hFF, 1'b1);
      settle();

      // Tall objects, table order, bottom line of the range, slots overflow
      write_csr(CSR_TALL_OBJECTS, 1'b1);
      write_csr(CSR_SORT_BY_X, 1'b0);
      send_entry(8'd239, 8'd255, 8'd255, 8'h00, 8'hFF, 1'b0);
      pace();
      send_entry(8'd239, 8'd240, 8'd0, 8'hFF, 8'h00, 1'b0);
      pace();
      send_entry(8'd239, 8'd239, 8'd7, 8'h55, 8'hAA, 1'b0);
      pace();
      for (i = 0; i < 10; i++) begin
         send_entry(8'd239, 8'd250, 8'(200 - 10 * i), 8'(i), 8'(8'hA0 | i), i == 9);
         pace();
      end

      // Line 255: Y 255 never fits
      send_entry(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
      pace();

      // Random scans with occasional register changes between them
      scan_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            if ($urandom_range(0, 3) != 0)
               write_csr(CSR_TALL_OBJECTS, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
               write_csr(CSR_SORT_BY_X, 1'($urandom_range(0, 1)));
         end
         if (scan_no == 2 || $urandom_range(0, 9) == 0)
            run_scan($urandom_range(TABLE_ENTRIES + 1, TABLE_ENTRIES + 4), 1'b1);
         else
            run_scan($urandom_range(1, 14), 1'b0);
         scan_no++;
      end

      settle();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sss_pkg.sv
rtl/core/sss_front.sv
rtl/core/sss_queue.sv
rtl/core/sss_back.sv
rtl/core/scanline_sprite_selector_unit.sv
bench/scanline_sprite_selector_checker.sv
bench/tb_scanline_sprite_selector_unit.sv
